// ===== hw/rtl/vec2a_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector ALU package
// Shared constants and the operation code type for the 2D vector ALU.
// ----------------------------------------------------------------------------
package vec2a_pkg;

	localparam int unsigned DataWidthDefault = 32;
	localparam int unsigned FracBitsDefault  = 16;
	localparam int unsigned ModeWidth        = 4;

	// Operation codes carried in the mode field of a request.
	typedef enum logic [ModeWidth-1:0] {
		MODE_ADD      = 4'd0,
		MODE_SUB      = 4'd1,
		MODE_MUL      = 4'd2,
		MODE_DIV      = 4'd3,
		MODE_SCALE    = 4'd4,
		MODE_SCALEDIV = 4'd5,
		MODE_NEGATE   = 4'd6,
		MODE_DOT      = 4'd7,
		MODE_MAGSQ    = 4'd8,
		MODE_MAG      = 4'd9,
		MODE_UNIT     = 4'd10
	} mode_t;

endpackage

// ===== hw/rtl/vec2a_req_if.sv =====
// ----------------------------------------------------------------------------
// Vector ALU request channel
// Valid/ready channel carrying one operation and its operands.
// ----------------------------------------------------------------------------
interface vec2a_req_if #(
	parameter int unsigned DATA_WIDTH = vec2a_pkg::DataWidthDefault
);
	logic                                 valid;
	logic                                 ready;
	logic [vec2a_pkg::ModeWidth-1:0]      mode;
	logic signed [DATA_WIDTH-1:0]         a_x;
	logic signed [DATA_WIDTH-1:0]         a_y;
	logic signed [DATA_WIDTH-1:0]         b_x;
	logic signed [DATA_WIDTH-1:0]         b_y;
	logic signed [DATA_WIDTH-1:0]         scale;

	modport source (output valid, mode, a_x, a_y, b_x, b_y, scale, input ready);
	modport sink   (input valid, mode, a_x, a_y, b_x, b_y, scale, output ready);
endinterface

// ===== hw/rtl/vec2a_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Vector ALU response channel
// Valid/ready channel carrying one result and its status flags.
// ----------------------------------------------------------------------------
interface vec2a_rsp_if #(
	parameter int unsigned DATA_WIDTH = vec2a_pkg::DataWidthDefault
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] res_x;
	logic signed [DATA_WIDTH-1:0] res_y;
	logic signed [DATA_WIDTH-1:0] res_scalar;
	logic                         overflow;
	logic                         div_by_zero;

	modport source (output valid, res_x, res_y, res_scalar, overflow, div_by_zero,
		input ready);
	modport sink   (input valid, res_x, res_y, res_scalar, overflow, div_by_zero,
		output ready);
endinterface

// ===== hw/rtl/vec2a_delay.sv =====
// ----------------------------------------------------------------------------
// Vector ALU delay line
// Carries side information alongside a pipelined unit, one stage per cycle while en is high.
// ----------------------------------------------------------------------------
module vec2a_delay #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[DEPTH-1];
endmodule

// ===== hw/rtl/vec2a_sqrt.sv =====
// ----------------------------------------------------------------------------
// Vector ALU square root
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vec2a_sqrt #(
	parameter int unsigned DATA_WIDTH = vec2a_pkg::DataWidthDefault
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [2*DATA_WIDTH-1:0]   sq,
	output logic [DATA_WIDTH-1:0]     root
);
	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned RW = DW + 2;

	logic [PW-1:0] val_q  [DW];
	logic [RW-1:0] rem_q  [DW];
	logic [DW-1:0] root_q [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [PW-1:0] val_in;
		logic [RW-1:0] rem_in;
		logic [DW-1:0] root_in;
		logic [RW+1:0] r2;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign val_in  = sq;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign val_in  = val_q[k-1];
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
		end

		// Bring down the next two bits and try root*4+1.
		assign r2    = {rem_in, val_in[PW-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign diff  = r2 - trial;
		assign ge    = (r2 >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				val_q[k]  <= {val_in[PW-3:0], 2'b00};
				rem_q[k]  <= ge ? diff[RW-1:0] : r2[RW-1:0];
				root_q[k] <= {root_in[DW-2:0], ge};
			end
		end
	end

	assign root = root_q[DW-1];
endmodule

// ===== hw/rtl/vec2a_div.sv =====
// ----------------------------------------------------------------------------
// Vector ALU divider lane
// Pipelined restoring divider of (dividend << FRAC_BITS) by an unsigned divisor.
// ----------------------------------------------------------------------------
module vec2a_div #(
	parameter int unsigned DATA_WIDTH = vec2a_pkg::DataWidthDefault,
	parameter int unsigned FRAC_BITS  = vec2a_pkg::FracBitsDefault
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [DATA_WIDTH-1:0]           dividend,
	input  logic [DATA_WIDTH-1:0]           divisor,
	output logic [DATA_WIDTH+FRAC_BITS-1:0] quot
);
	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;

	logic [DW-1:0] rem_q [QW];
	logic [QW-1:0] nq_q  [QW];
	logic [DW-1:0] d_q   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [QW-1:0] nq_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   r2;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = {dividend, {FRAC_BITS{1'b0}}};
			assign d_in   = divisor;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign nq_in  = nq_q[k-1];
			assign d_in   = d_q[k-1];
		end

		// The dividend shifts out at the top while quotient bits fill in below.
		assign r2   = {rem_in, nq_in[QW-1]};
		assign diff = r2 - {1'b0, d_in};
		assign ge   = (r2 >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
				nq_q[k]  <= {nq_in[QW-2:0], ge};
				d_q[k]   <= d_in;
			end
		end
	end

	assign quot = nq_q[QW-1];
endmodule

// ===== hw/rtl/vector_2d_alu.sv =====
// ----------------------------------------------------------------------------
// 2D vector ALU
// Fixed-point vector arithmetic with saturation, square root and division.
// ----------------------------------------------------------------------------
//
//  Channel | Role   | Payload
//  --------+--------+-----------------------------------------------------
//  req     | sink   | mode, a_x, a_y, b_x, b_y, scale
//  rsp     | source | res_x, res_y, res_scalar, overflow, div_by_zero
//
// One request is taken per cycle while the pipeline advances. Each request
// passes through the front stages, the square root, the divider lanes and
// the output register; the bit-per-stage square root and the two divider
// lanes set the depth. Reset clears the stage valid bits and the output
// valid. When a result waits in the output register the pipeline keeps moving
// as long as its last stage is empty, so new requests are still taken; the
// whole pipeline holds only when the last stage and the output are both full
// and the response is not taken.
//
module vector_2d_alu #(
	parameter int unsigned DATA_WIDTH = vec2a_pkg::DataWidthDefault,
	parameter int unsigned FRAC_BITS  = vec2a_pkg::FracBitsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	vec2a_req_if.sink     req,
	vec2a_rsp_if.source   rsp
);
	localparam int unsigned DW  = DATA_WIDTH;
	localparam int unsigned PW  = 2 * DW;
	localparam int unsigned QW  = DW + FRAC_BITS;
	localparam int unsigned MW  = (PW > QW) ? PW : QW;
	localparam int unsigned L   = 2 + DW + QW;
	localparam int unsigned MDW = vec2a_pkg::ModeWidth;
	localparam int unsigned S1W = MDW + 7 * DW + 7;
	localparam int unsigned S2W = MDW + 4 * DW + 7;

	localparam logic [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};
	localparam logic [MW-1:0] PosLim = {{(MW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [MW-1:0] NegLim = {{(MW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

	// Magnitude of a two's complement value; the minimum maps to 2^(DW-1).
	function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	// True when a sign-magnitude value lies outside the signed range.
	function automatic logic sat_ovf(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		lim = neg ? NegLim : PosLim;
		return (m > lim);
	endfunction

	// Clamp a sign-magnitude value and return it in two's complement.
	function automatic logic [DW-1:0] sat_val(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		logic [DW-1:0] v;
		lim = neg ? NegLim : PosLim;
		v   = (m > lim) ? lim[DW-1:0] : m[DW-1:0];
		return neg ? (~v + 1'b1) : v;
	endfunction

	// ------------------------------------------------------------------
	// Flow control: one global advance for all stages.
	// ------------------------------------------------------------------
	logic [L-1:0] vld_q;
	logic         out_v_q;
	logic         advance;

	assign advance   = !vld_q[L-1] || !out_v_q || rsp.ready;
	assign req.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[L-2:0], req.valid};
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: operand magnitudes, one multiplier per lane, add/sub/negate.
	// ------------------------------------------------------------------
	vec2a_pkg::mode_t md_in;
	logic [DW-1:0]    ax_m, ay_m, bx_m, by_m, sc_m;
	logic [DW-1:0]    opx, opy, dvx, dvy;
	logic             opxn, opyn, dvxn, dvyn;
	logic [DW:0]      lsx, lsy;
	logic [PW-1:0]    prod_x, prod_y;

	assign md_in = vec2a_pkg::mode_t'(req.mode);
	assign ax_m  = mag_of(req.a_x);
	assign ay_m  = mag_of(req.a_y);
	assign bx_m  = mag_of(req.b_x);
	assign by_m  = mag_of(req.b_y);
	assign sc_m  = mag_of(req.scale);

	always_comb begin
		opx  = bx_m;
		opy  = by_m;
		opxn = req.b_x[DW-1];
		opyn = req.b_y[DW-1];
		dvx  = bx_m;
		dvy  = by_m;
		dvxn = req.b_x[DW-1];
		dvyn = req.b_y[DW-1];
		lsx  = '0;
		lsy  = '0;
		case (md_in)
			vec2a_pkg::MODE_ADD: begin
				lsx = {req.a_x[DW-1], req.a_x} + {req.b_x[DW-1], req.b_x};
				lsy = {req.a_y[DW-1], req.a_y} + {req.b_y[DW-1], req.b_y};
			end
			vec2a_pkg::MODE_SUB: begin
				lsx = {req.a_x[DW-1], req.a_x} - {req.b_x[DW-1], req.b_x};
				lsy = {req.a_y[DW-1], req.a_y} - {req.b_y[DW-1], req.b_y};
			end
			vec2a_pkg::MODE_NEGATE: begin
				lsx = '0 - {req.a_x[DW-1], req.a_x};
				lsy = '0 - {req.a_y[DW-1], req.a_y};
			end
			vec2a_pkg::MODE_SCALE: begin
				opx  = sc_m;
				opy  = sc_m;
				opxn = req.scale[DW-1];
				opyn = req.scale[DW-1];
			end
			vec2a_pkg::MODE_SCALEDIV: begin
				dvx  = sc_m;
				dvy  = sc_m;
				dvxn = req.scale[DW-1];
				dvyn = req.scale[DW-1];
			end
			vec2a_pkg::MODE_MAGSQ, vec2a_pkg::MODE_MAG, vec2a_pkg::MODE_UNIT: begin
				opx  = ax_m;
				opy  = ay_m;
				opxn = req.a_x[DW-1];
				opyn = req.a_y[DW-1];
			end
			default: begin
			end
		endcase
	end

	assign prod_x = PW'(ax_m) * PW'(opx);
	assign prod_y = PW'(ay_m) * PW'(opy);

	vec2a_pkg::mode_t md_s1;
	logic [PW-1:0]    px_s1, py_s1;
	logic             pxn_s1, pyn_s1;
	logic [DW-1:0]    amx_s1, amy_s1, dmx_s1, dmy_s1;
	logic             qnx_s1, qny_s1, axn_s1, ayn_s1, dzx_s1, dzy_s1;
	logic [DW-1:0]    lrx_s1, lry_s1;
	logic             lovf_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			md_s1   <= md_in;
			px_s1   <= prod_x;
			py_s1   <= prod_y;
			pxn_s1  <= req.a_x[DW-1] ^ opxn;
			pyn_s1  <= req.a_y[DW-1] ^ opyn;
			amx_s1  <= ax_m;
			amy_s1  <= ay_m;
			dmx_s1  <= dvx;
			dmy_s1  <= dvy;
			// The unit vector keeps the sign of the input component.
			qnx_s1  <= (md_in == vec2a_pkg::MODE_UNIT) ? req.a_x[DW-1]
				: (req.a_x[DW-1] ^ dvxn);
			qny_s1  <= (md_in == vec2a_pkg::MODE_UNIT) ? req.a_y[DW-1]
				: (req.a_y[DW-1] ^ dvyn);
			axn_s1  <= req.a_x[DW-1];
			ayn_s1  <= req.a_y[DW-1];
			dzx_s1  <= (dvx == '0);
			dzy_s1  <= (dvy == '0);
			// Add, subtract and negate overflow when the two top bits differ.
			lrx_s1  <= (lsx[DW] ^ lsx[DW-1]) ? (lsx[DW] ? MinVal : MaxVal) : lsx[DW-1:0];
			lry_s1  <= (lsy[DW] ^ lsy[DW-1]) ? (lsy[DW] ? MinVal : MaxVal) : lsy[DW-1:0];
			lovf_s1 <= (lsx[DW] ^ lsx[DW-1]) | (lsy[DW] ^ lsy[DW-1]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: merge the lane products into dot and sum of squares, and
	// saturate every result that needs no root or division.
	// ------------------------------------------------------------------
	logic [PW-1:0] sq, dsum;
	logic          dneg;
	logic [DW-1:0] c_rx, c_ry, c_rs;
	logic          c_ovf;
	logic [S1W-1:0] side1_in;

	assign sq = px_s1 + py_s1;

	always_comb begin
		if (pxn_s1 == pyn_s1) begin
			dsum = px_s1 + py_s1;
			dneg = pxn_s1;
		end else if (px_s1 >= py_s1) begin
			dsum = px_s1 - py_s1;
			dneg = pxn_s1;
		end else begin
			dsum = py_s1 - px_s1;
			dneg = pyn_s1;
		end
	end

	always_comb begin
		c_rx  = '0;
		c_ry  = '0;
		c_rs  = '0;
		c_ovf = 1'b0;
		case (md_s1)
			vec2a_pkg::MODE_ADD, vec2a_pkg::MODE_SUB, vec2a_pkg::MODE_NEGATE: begin
				c_rx  = lrx_s1;
				c_ry  = lry_s1;
				c_ovf = lovf_s1;
			end
			vec2a_pkg::MODE_MUL, vec2a_pkg::MODE_SCALE: begin
				c_rx  = sat_val(pxn_s1, MW'(px_s1 >> FRAC_BITS));
				c_ry  = sat_val(pyn_s1, MW'(py_s1 >> FRAC_BITS));
				c_ovf = sat_ovf(pxn_s1, MW'(px_s1 >> FRAC_BITS))
					| sat_ovf(pyn_s1, MW'(py_s1 >> FRAC_BITS));
			end
			vec2a_pkg::MODE_DOT: begin
				c_rs  = sat_val(dneg, MW'(dsum >> FRAC_BITS));
				c_ovf = sat_ovf(dneg, MW'(dsum >> FRAC_BITS));
			end
			vec2a_pkg::MODE_MAGSQ: begin
				c_rs  = sat_val(1'b0, MW'(sq >> FRAC_BITS));
				c_ovf = sat_ovf(1'b0, MW'(sq >> FRAC_BITS));
			end
			default: begin
			end
		endcase
	end

	assign side1_in = {md_s1, amx_s1, amy_s1, dmx_s1, dmy_s1,
		qnx_s1, qny_s1, axn_s1, ayn_s1, dzx_s1, dzy_s1,
		c_rx, c_ry, c_rs, c_ovf};

	logic [PW-1:0]  sq_s2;
	logic [S1W-1:0] side1_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			sq_s2    <= sq;
			side1_s2 <= side1_in;
		end
	end

	// ------------------------------------------------------------------
	// Square root, with the rest of the request riding alongside.
	// ------------------------------------------------------------------
	logic [DW-1:0]  root;
	logic [S1W-1:0] side1_out;

	vec2a_sqrt #(.DATA_WIDTH(DW)) u_sqrt (
		.clk  (clk),
		.en   (advance),
		.sq   (sq_s2),
		.root (root)
	);

	vec2a_delay #(.W(S1W), .DEPTH(DW)) u_dly_root (
		.clk (clk),
		.en  (advance),
		.d   (side1_s2),
		.q   (side1_out)
	);

	logic [MDW-1:0] r_md;
	logic [DW-1:0]  r_amx, r_amy, r_dmx, r_dmy, r_rx, r_ry, r_rs;
	logic           r_qnx, r_qny, r_axn, r_ayn, r_dzx, r_dzy, r_ovf;

	assign {r_md, r_amx, r_amy, r_dmx, r_dmy, r_qnx, r_qny, r_axn, r_ayn,
		r_dzx, r_dzy, r_rx, r_ry, r_rs, r_ovf} = side1_out;

	// ------------------------------------------------------------------
	// Divider lanes: the unit vector divides by the root, the divide modes
	// by their own divisor.
	// ------------------------------------------------------------------
	logic           r_unit;
	logic [DW-1:0]  div_x, div_y;
	logic [QW-1:0]  quot_x, quot_y;
	logic [S2W-1:0] side2_in, side2_out;

	assign r_unit = (vec2a_pkg::mode_t'(r_md) == vec2a_pkg::MODE_UNIT);
	assign div_x  = r_unit ? root : r_dmx;
	assign div_y  = r_unit ? root : r_dmy;

	vec2a_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk      (clk),
		.en       (advance),
		.dividend (r_amx),
		.divisor  (div_x),
		.quot     (quot_x)
	);

	vec2a_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk      (clk),
		.en       (advance),
		.dividend (r_amy),
		.divisor  (div_y),
		.quot     (quot_y)
	);

	assign side2_in = {r_md, r_qnx, r_qny, r_axn, r_ayn, r_dzx, r_dzy,
		r_rx, r_ry, r_rs, r_ovf, root};

	vec2a_delay #(.W(S2W), .DEPTH(QW)) u_dly_div (
		.clk (clk),
		.en  (advance),
		.d   (side2_in),
		.q   (side2_out)
	);

	logic [MDW-1:0] f_md;
	logic           f_qnx, f_qny, f_axn, f_ayn, f_dzx, f_dzy, f_ovf;
	logic [DW-1:0]  f_rx, f_ry, f_rs, f_root;

	assign {f_md, f_qnx, f_qny, f_axn, f_ayn, f_dzx, f_dzy,
		f_rx, f_ry, f_rs, f_ovf, f_root} = side2_out;

	// ------------------------------------------------------------------
	// Final merge: pick the lane quotients, the root or the early result.
	// A zero divisor clamps toward the dividend's sign and flags it.
	// ------------------------------------------------------------------
	logic [DW-1:0] m_rx, m_ry, m_rs;
	logic          m_ovf, m_dz;

	always_comb begin
		m_rx  = f_rx;
		m_ry  = f_ry;
		m_rs  = f_rs;
		m_ovf = f_ovf;
		m_dz  = 1'b0;
		case (vec2a_pkg::mode_t'(f_md))
			vec2a_pkg::MODE_DIV, vec2a_pkg::MODE_SCALEDIV: begin
				m_ovf = 1'b0;
				if (f_dzx) begin
					m_rx = f_axn ? MinVal : MaxVal;
					m_dz = 1'b1;
				end else begin
					m_rx  = sat_val(f_qnx, MW'(quot_x));
					m_ovf = sat_ovf(f_qnx, MW'(quot_x));
				end
				if (f_dzy) begin
					m_ry = f_ayn ? MinVal : MaxVal;
					m_dz = 1'b1;
				end else begin
					m_ry  = sat_val(f_qny, MW'(quot_y));
					m_ovf = m_ovf | sat_ovf(f_qny, MW'(quot_y));
				end
			end
			vec2a_pkg::MODE_MAG: begin
				m_rs  = sat_val(1'b0, MW'(f_root));
				m_ovf = sat_ovf(1'b0, MW'(f_root));
			end
			vec2a_pkg::MODE_UNIT: begin
				// A zero magnitude only comes from the zero vector: result (0,0).
				if (f_root != '0) begin
					m_rx  = sat_val(f_qnx, MW'(quot_x));
					m_ry  = sat_val(f_qny, MW'(quot_y));
					m_ovf = sat_ovf(f_qnx, MW'(quot_x)) | sat_ovf(f_qny, MW'(quot_y));
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic load;

	assign load = vld_q[L-1] && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	logic [DW-1:0] rx_q, ry_q, rs_q;
	logic          ovf_q, dz_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rx_q  <= m_rx;
			ry_q  <= m_ry;
			rs_q  <= m_rs;
			ovf_q <= m_ovf;
			dz_q  <= m_dz;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.res_x       = rx_q;
	assign rsp.res_y       = ry_q;
	assign rsp.res_scalar  = rs_q;
	assign rsp.overflow    = ovf_q;
	assign rsp.div_by_zero = dz_q;
endmodule
